FILE: rtl/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg
// shared constants, codes and the result type of the P6 stream decoder
// ----------------------------------------------------------------------------
package ppm_pkg;

    // file bytes past this count are ignored
    localparam int unsigned MAX_FILE_BYTES = 32768;
    localparam int unsigned MIN_FILE_BYTES = 11;

    // result queue
    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
    localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

    // register map
    localparam logic [1:0] REG_WINDOW_WIDTH   = 2'd0;
    localparam logic [1:0] REG_CONTENT_TOP    = 2'd1;
    localparam logic [1:0] REG_CONTENT_HEIGHT = 2'd2;

    localparam logic [9:0] RST_WINDOW_WIDTH   = 10'd400;
    localparam logic [9:0] RST_CONTENT_TOP    = 10'd22;
    localparam logic [9:0] RST_CONTENT_HEIGHT = 10'd274;

    // parse phases
    localparam logic [2:0] PH_MAGIC_P = 3'd0;
    localparam logic [2:0] PH_MAGIC_6 = 3'd1;
    localparam logic [2:0] PH_FIELD_W = 3'd2;
    localparam logic [2:0] PH_FIELD_H = 3'd3;
    localparam logic [2:0] PH_FIELD_M = 3'd4;
    localparam logic [2:0] PH_DATA    = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;
    localparam logic [2:0] PH_ERROR   = 3'd7;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_HDR   = 3'd2;
    localparam logic [2:0] ST_BAD_MAX   = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;
    localparam logic [2:0] ST_SHORT     = 3'd5;

    // result kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // characters
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [15:0] MAXVAL_OK  = 16'd255;
    localparam logic [19:0] NUM_LIMIT  = 20'd65535;

    typedef struct packed {
        logic        kind;
        logic [9:0]  dest_x;
        logic [10:0] dest_y;
        logic [23:0] rgb;
        logic [2:0]  status;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        last;
    } t_result;

endpackage

FILE: rtl/ppm_p6_stream_decoder.sv
// ----------------------------------------------------------------------------
// ppm_p6_stream_decoder
// byte-serial P6 PPM parser with centered, clipped pixel placement
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ------------------------------------
//  byte in   input      i_valid / o_ready    i_data_byte, i_end_of_file
//  result    output     o_valid / i_ready    o_kind, o_dest_x, o_dest_y, o_rgb,
//                                            o_status, o_image_width,
//                                            o_image_height, o_last
//  config    input      psel/penable/pwrite  paddr, pwdata, prdata, pready
//
//  one byte is taken per cycle while o_ready is high; all parsing and pixel
//  placement is done in the cycle of acceptance and the results land in a
//  four-entry result queue; o_ready drops only while the queue holds three or
//  more results, i.e. when the output side has stalled; a beat can yield up to
//  two results (a pixel and the end-of-file status)
//  synchronous active-low reset clears parse state and queue, presets registers
//  no clearing pass, the block takes bytes from the first cycle after reset
// ----------------------------------------------------------------------------
module ppm_p6_stream_decoder
    import ppm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,

    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [9:0]  o_dest_x,
    output logic [10:0] o_dest_y,
    output logic [23:0] o_rgb,
    output logic [2:0]  o_status,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic        o_last,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [9:0] r_window_width;
    logic [9:0] r_content_top;
    logic [9:0] r_content_height;

    // parse state
    logic [2:0]  r_phase,       n_phase;
    logic        r_in_comment,  n_in_comment;
    logic [15:0] r_acc,         n_acc;
    logic        r_digit_seen,  n_digit_seen;
    logic [15:0] r_width,       n_width;
    logic [15:0] r_height,      n_height;
    logic [15:0] r_byte_count,  n_byte_count;
    logic [1:0]  r_chan,        n_chan;
    logic [15:0] r_partial,     n_partial;
    logic [15:0] r_col,         n_col;
    logic [15:0] r_row,         n_row;
    logic [2:0]  r_err,         n_err;

    // result queue
    t_result                r_queue [RES_DEPTH];
    logic [RES_PTR_W-1:0]   r_wr_ptr;
    logic [RES_PTR_W-1:0]   r_rd_ptr;
    logic [RES_CNT_W-1:0]   r_count;

    logic       in_beat;
    logic       out_beat;
    logic       cfg_write;
    logic       push_pix;
    logic       push_stat;
    logic       field_cont;
    logic [2:0] stat_code;
    t_result    pix_res;
    t_result    stat_res;

    // byte classes
    logic        is_digit;
    logic        is_space;
    logic [19:0] acc_next;

    // placement
    logic [9:0]  draw_w;
    logic [9:0]  draw_h;
    logic [9:0]  off_x;
    logic [8:0]  half_y;
    logic [11:0] pos_y;
    logic        pix_inside;

    logic [RES_PTR_W-1:0] stat_slot;
    logic [RES_CNT_W-1:0] push_cnt;

    assign in_beat   = i_valid & o_ready;
    assign out_beat  = o_valid & i_ready;
    assign cfg_write = psel & penable & pwrite & pready;
    assign pready    = 1'b1;

    // room for the worst case of two results per beat
    assign o_ready = (r_count <= RES_CNT_W'(RES_DEPTH - 2));
    assign o_valid = (r_count != '0);

    assign is_digit = (i_data_byte >= CH_0) && (i_data_byte <= CH_9);
    assign is_space = (i_data_byte == CH_SPACE) || (i_data_byte == CH_TAB)
                   || (i_data_byte == CH_CR) || (i_data_byte == CH_LF);
    // acc * 10 + digit, wide enough to see an overflow past 16 bits
    assign acc_next = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                    + {16'd0, i_data_byte[3:0]};

    // clip to the window and the content area, center what remains
    assign draw_w = (r_width < {6'd0, r_window_width}) ? r_width[9:0] : r_window_width;
    assign draw_h = (r_height < {6'd0, r_content_height}) ? r_height[9:0]
                                                           : r_content_height;
    assign off_x  = (r_window_width - draw_w) >> 1;
    assign half_y = 9'((r_content_height - draw_h) >> 1);
    assign pos_y  = {2'd0, r_content_top} + {3'd0, half_y} + {2'd0, r_row[9:0]};
    assign pix_inside = (r_col < {6'd0, draw_w}) && (r_row < {6'd0, draw_h});

    always_comb begin
        pix_res.kind         = KIND_PIXEL;
        pix_res.dest_x       = off_x + r_col[9:0];
        pix_res.dest_y       = pos_y[10:0];
        pix_res.rgb          = {r_partial, i_data_byte};
        pix_res.status       = ST_OK;
        pix_res.image_width  = '0;
        pix_res.image_height = '0;
        pix_res.last         = 1'b0;
    end

    // parse step for one accepted beat
    always_comb begin
        n_phase      = r_phase;
        n_in_comment = r_in_comment;
        n_acc        = r_acc;
        n_digit_seen = r_digit_seen;
        n_width      = r_width;
        n_height     = r_height;
        n_byte_count = r_byte_count;
        n_chan       = r_chan;
        n_partial    = r_partial;
        n_col        = r_col;
        n_row        = r_row;
        n_err        = r_err;
        push_pix     = 1'b0;
        push_stat    = 1'b0;
        field_cont   = 1'b0;
        stat_code    = ST_OK;

        if (in_beat) begin
            if (r_byte_count < 16'(MAX_FILE_BYTES)) begin
                n_byte_count = r_byte_count + 16'd1;
                case (r_phase)
                    PH_MAGIC_P: begin
                        if (i_data_byte == CH_P) begin
                            n_phase = PH_MAGIC_6;
                        end else begin
                            n_phase = PH_ERROR;
                            n_err   = ST_BAD_MAGIC;
                        end
                    end
                    PH_MAGIC_6: begin
                        if (i_data_byte == CH_6) begin
                            n_phase = PH_FIELD_W;
                        end else begin
                            n_phase = PH_ERROR;
                            n_err   = ST_BAD_MAGIC;
                        end
                    end
                    PH_FIELD_W, PH_FIELD_H, PH_FIELD_M: begin
                        field_cont = 1'b1;
                        if (r_digit_seen) begin
                            if (is_digit) begin
                                field_cont = 1'b0;
                                n_acc      = acc_next[15:0];
                                if (acc_next > NUM_LIMIT) begin
                                    n_phase = PH_ERROR;
                                    n_err   = ST_BAD_HDR;
                                end
                            end else begin
                                // number ends on this byte
                                n_digit_seen = 1'b0;
                                n_acc        = '0;
                                if (r_acc == '0) begin
                                    field_cont = 1'b0;
                                    n_phase    = PH_ERROR;
                                    n_err      = ST_BAD_HDR;
                                end else if (r_phase == PH_FIELD_W) begin
                                    n_width = r_acc;
                                    n_phase = PH_FIELD_H;
                                end else if (r_phase == PH_FIELD_H) begin
                                    n_height = r_acc;
                                    n_phase  = PH_FIELD_M;
                                end else begin
                                    // maxval: the ending byte is the single separator
                                    field_cont = 1'b0;
                                    if (r_acc != MAXVAL_OK) begin
                                        n_phase = PH_ERROR;
                                        n_err   = ST_BAD_MAX;
                                    end else begin
                                        n_phase = PH_DATA;
                                    end
                                end
                            end
                        end
                        if (field_cont) begin
                            if (r_in_comment) begin
                                if (i_data_byte == CH_LF) begin
                                    n_in_comment = 1'b0;
                                end
                            end else if (is_space) begin
                                n_in_comment = r_in_comment;
                            end else if (i_data_byte == CH_HASH) begin
                                n_in_comment = 1'b1;
                            end else if (is_digit) begin
                                n_digit_seen = 1'b1;
                                n_acc        = {12'd0, i_data_byte[3:0]};
                            end else begin
                                n_phase = PH_ERROR;
                                n_err   = ST_BAD_HDR;
                            end
                        end
                    end
                    PH_DATA: begin
                        case (r_chan)
                            2'd1: begin
                                n_partial = {r_partial[7:0], i_data_byte};
                                n_chan    = 2'd2;
                            end
                            2'd2: begin
                                n_chan    = 2'd0;
                                n_partial = '0;
                                push_pix  = pix_inside;
                                if ((r_col + 16'd1) >= r_width) begin
                                    n_col = '0;
                                    n_row = r_row + 16'd1;
                                    if ((r_row + 16'd1) >= r_height) begin
                                        n_phase = PH_DONE;
                                    end
                                end else begin
                                    n_col = r_col + 16'd1;
                                end
                            end
                            default: begin
                                n_partial = {8'd0, i_data_byte};
                                n_chan    = 2'd1;
                            end
                        endcase
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end

            if (i_end_of_file) begin
                push_stat = 1'b1;
                if (n_byte_count < 16'(MIN_FILE_BYTES)) begin
                    stat_code = ST_SHORT;
                end else begin
                    case (n_phase)
                        PH_ERROR:   stat_code = n_err;
                        PH_MAGIC_P: stat_code = ST_BAD_MAGIC;
                        PH_MAGIC_6: stat_code = ST_BAD_MAGIC;
                        PH_FIELD_M: begin
                            if (!n_digit_seen || (n_acc == '0)) begin
                                stat_code = ST_BAD_HDR;
                            end else if (n_acc != MAXVAL_OK) begin
                                stat_code = ST_BAD_MAX;
                            end else begin
                                stat_code = ST_TRUNC;
                            end
                        end
                        PH_DATA:    stat_code = ST_TRUNC;
                        PH_DONE:    stat_code = ST_OK;
                        default:    stat_code = ST_BAD_HDR;
                    endcase
                end
                // next byte starts a new file
                n_phase      = PH_MAGIC_P;
                n_in_comment = 1'b0;
                n_acc        = '0;
                n_digit_seen = 1'b0;
                n_width      = '0;
                n_height     = '0;
                n_byte_count = '0;
                n_chan       = 2'd0;
                n_partial    = '0;
                n_col        = '0;
                n_row        = '0;
                n_err        = ST_OK;
            end
        end
    end

    always_comb begin
        stat_res.kind         = KIND_STATUS;
        stat_res.dest_x       = '0;
        stat_res.dest_y       = '0;
        stat_res.rgb          = '0;
        stat_res.status       = stat_code;
        stat_res.image_width  = n_width;
        stat_res.image_height = n_height;
        stat_res.last         = 1'b1;
        if (i_end_of_file) begin
            // sizes as seen before the clear
            stat_res.image_width  = (r_phase == PH_FIELD_W && r_digit_seen && !is_digit
                                     && r_acc != '0 && r_byte_count < 16'(MAX_FILE_BYTES))
                                    ? r_acc : r_width;
            stat_res.image_height = (r_phase == PH_FIELD_H && r_digit_seen && !is_digit
                                     && r_acc != '0 && r_byte_count < 16'(MAX_FILE_BYTES))
                                    ? r_acc : r_height;
        end
    end

    // status goes behind the pixel of the same beat
    assign stat_slot = r_wr_ptr + RES_PTR_W'(push_pix);
    assign push_cnt  = RES_CNT_W'(push_pix) + RES_CNT_W'(push_stat);

    always_ff @(posedge i_clk) begin
        if (push_pix) begin
            r_queue[r_wr_ptr] <= pix_res;
        end
        if (push_stat) begin
            r_queue[stat_slot] <= stat_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RES_PTR_W'(push_cnt);
            if (out_beat) begin
                r_rd_ptr <= r_rd_ptr + RES_PTR_W'(1);
            end
            r_count <= r_count + push_cnt - RES_CNT_W'(out_beat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAGIC_P;
            r_in_comment <= 1'b0;
            r_acc        <= '0;
            r_digit_seen <= 1'b0;
            r_width      <= '0;
            r_height     <= '0;
            r_byte_count <= '0;
            r_chan       <= 2'd0;
            r_partial    <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_err        <= ST_OK;
        end else begin
            r_phase      <= n_phase;
            r_in_comment <= n_in_comment;
            r_acc        <= n_acc;
            r_digit_seen <= n_digit_seen;
            r_width      <= n_width;
            r_height     <= n_height;
            r_byte_count <= n_byte_count;
            r_chan       <= n_chan;
            r_partial    <= n_partial;
            r_col        <= n_col;
            r_row        <= n_row;
            r_err        <= n_err;
        end
    end

    // configuration writes, word address in paddr[3:2]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_width   <= RST_WINDOW_WIDTH;
            r_content_top    <= RST_CONTENT_TOP;
            r_content_height <= RST_CONTENT_HEIGHT;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_WINDOW_WIDTH:   r_window_width   <= pwdata[9:0];
                REG_CONTENT_TOP:    r_content_top    <= pwdata[9:0];
                REG_CONTENT_HEIGHT: r_content_height <= pwdata[9:0];
                default:            r_window_width   <= r_window_width;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WINDOW_WIDTH:   prdata = {22'd0, r_window_width};
            REG_CONTENT_TOP:    prdata = {22'd0, r_content_top};
            REG_CONTENT_HEIGHT: prdata = {22'd0, r_content_height};
            default:            prdata = '0;
        endcase
    end

    // head of the result queue
    assign o_kind         = r_queue[r_rd_ptr].kind;
    assign o_dest_x       = r_queue[r_rd_ptr].dest_x;
    assign o_dest_y       = r_queue[r_rd_ptr].dest_y;
    assign o_rgb          = r_queue[r_rd_ptr].rgb;
    assign o_status       = r_queue[r_rd_ptr].status;
    assign o_image_width  = r_queue[r_rd_ptr].image_width;
    assign o_image_height = r_queue[r_rd_ptr].image_height;
    assign o_last         = r_queue[r_rd_ptr].last;

endmodule
